// ===== hw/rtl/sra_pkg.sv =====
// ----------------------------------------------------------------------------
// sra_pkg
// Shared constants, types and angle helpers for the rotor angle pipeline.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int unsigned CordicIterDefault = 16;
  localparam int unsigned AtanTabLen        = 32;

  localparam int unsigned RotW = 33;   // Q30 sine/cosine with headroom
  localparam int unsigned ZrW  = 32;   // rotation angle, hundredths * 2^16
  localparam int unsigned VecW = 50;   // scaled numerator/denominator
  localparam int unsigned ZvW  = 34;   // vectoring angle accumulator

  localparam logic signed [RotW-1:0] GainQ30   = 33'sd652032874;
  localparam logic signed [VecW-1:0] RcRadius  = 50'sd42164;
  localparam logic signed [VecW-1:0] ReRadius  = 50'sd6348;
  localparam logic signed [17:0]     AngFull   = 18'sd36000;
  localparam logic signed [17:0]     AngHalf   = 18'sd18000;
  localparam logic signed [17:0]     AngQuart  = 18'sd9000;

  // register byte addresses
  localparam logic [2:0] AddrSiteLon = 3'd0;
  localparam logic [2:0] AddrSiteLat = 3'd4;

  // atan(2^-i) in hundredths of a degree * 2^16
  localparam logic signed [31:0] ATAN_TAB [AtanTabLen] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
    32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
    32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
    32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
    32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
    32'sd358,       32'sd179,       32'sd90,       32'sd45,
    32'sd22,        32'sd11,        32'sd6,        32'sd3,
    32'sd1,         32'sd1,         32'sd0,        32'sd0
  };

  typedef struct packed {
    logic signed [14:0] ang;
    logic               flip;
  } sra_fold_t;

  // result override for a zero denominator
  typedef struct packed {
    logic               zero;
    logic signed [14:0] val;
  } sra_side_t;

  // reduce into (-18000, 18000]; input spans at most +-65535
  function automatic logic signed [17:0] sra_wrap(input logic signed [17:0] d);
    logic signed [17:0] a;
    a = d;
    if (a > AngHalf) a = a - AngFull;
    if (a > AngHalf) a = a - AngFull;
    if (a <= -AngHalf) a = a + AngFull;
    if (a <= -AngHalf) a = a + AngFull;
    return a;
  endfunction

  // fold into +-90 degrees, flip marks a sign change of sine and cosine
  function automatic sra_fold_t sra_fold(input logic signed [17:0] d);
    logic signed [17:0] a;
    sra_fold_t          r;
    a = sra_wrap(d);
    r.flip = 1'b0;
    if (a > AngQuart) begin
      a = a - AngHalf;
      r.flip = 1'b1;
    end else if (a < -AngQuart) begin
      a = a + AngHalf;
      r.flip = 1'b1;
    end
    r.ang = a[14:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/satellite_rotor_angle.sv =====
// ----------------------------------------------------------------------------
// satellite_rotor_angle
// Dish rotor angle for a geostationary satellite at the configured site.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: the satellite
//   longitude. Output channel (out_valid_o / out_stall_i) returns one item
//   per input: the rotor angle, hundredths of a degree, within +-9000.
//   Site longitude and latitude (byte addresses 0 and 4) reset to 0. Write
//   them over the APB port only while the block is idle; it is not enforced.
// Pipeline: range fold, N sine/cosine stages (N = CORDIC_ITERATIONS,
//   capped at 32), multiply, denominator fix-up, N arctangent stages,
//   rounding into the output register.
// Throughput: one item per cycle while out_stall_i is low, set by the fully unrolled CORDIC stages.
// Stall: each stage holds while its successor is full and stalled, so
//   bubbles collapse and a new item is taken as long as the first stage
//   is free; nothing is lost or repeated.
// Reset: clears all valid bits and the site registers; no clearing pass.
// ----------------------------------------------------------------------------
module satellite_rotor_angle import sra_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = CordicIterDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] satellite_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] rotor_angle_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned N  = (CORDIC_ITERATIONS > AtanTabLen) ? AtanTabLen
                                                                : CORDIC_ITERATIONS;
  localparam int unsigned NS = 2 * N + 4;
  localparam int unsigned SM = N + 1;   // multiply stage
  localparam int unsigned SD = N + 2;   // denominator stage
  localparam int unsigned SV = N + 3;   // first arctangent stage

  // configuration
  logic signed [15:0] lon_q;
  logic signed [14:0] lat_q;
  logic               wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lon_q <= '0;
      lat_q <= '0;
    end else if (wr) begin
      if (paddr == AddrSiteLon) lon_q <= pwdata[15:0];
      if (paddr == AddrSiteLat) lat_q <= pwdata[14:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr)
      AddrSiteLon: prdata = {16'd0, lon_q};
      AddrSiteLat: prdata = {17'd0, lat_q};
      default:     prdata = '0;
    endcase
  end

  // valid chain and per-stage enables
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o = !en[0];

  // stage 0: range reduction and quadrant fold
  sra_fold_t fd, fl;
  sra_fold_t fd_q, fl_q;

  assign fd = sra_fold(18'(satellite_position_i) - 18'(lon_q));
  assign fl = sra_fold(18'(lat_q));

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      fd_q <= fd;
      fl_q <= fl;
    end
  end

  logic signed [ZrW-1:0]  zd0, zl0;
  logic signed [RotW-1:0] sd, cd, sl, cl;

  assign zd0 = {{(ZrW-31){fd_q.ang[14]}}, fd_q.ang, 16'd0};
  assign zl0 = {{(ZrW-31){fl_q.ang[14]}}, fl_q.ang, 16'd0};

  sra_rot #(.ITER(N)) u_rot_lon (
    .clk_i  (clk_i),
    .en_i   (en[N:1]),
    .z_i    (zd0),
    .flip_i (fd_q.flip),
    .sin_o  (sd),
    .cos_o  (cd)
  );

  sra_rot #(.ITER(N)) u_rot_lat (
    .clk_i  (clk_i),
    .en_i   (en[N:1]),
    .z_i    (zl0),
    .flip_i (fl_q.flip),
    .sin_o  (sl),
    .cos_o  (cl)
  );

  // scale by orbit and earth radii
  logic signed [VecW-1:0] num_q, rcc_q, rec_q;

  always_ff @(posedge clk_i) begin
    if (en[SM]) begin
      num_q <= VecW'(sd) * RcRadius;
      rcc_q <= VecW'(cd) * RcRadius;
      rec_q <= VecW'(cl) * ReRadius;
    end
  end

  // denominator, sign normalization, zero-denominator override
  logic signed [VecW-1:0] den;
  logic signed [VecW-1:0] vx_q, vy_q;
  sra_side_t              side_q;

  assign den = rcc_q - rec_q;

  always_ff @(posedge clk_i) begin
    if (en[SD]) begin
      vx_q        <= den[VecW-1] ? -den : den;
      vy_q        <= den[VecW-1] ? -num_q : num_q;
      side_q.zero <= (den == '0);
      if (num_q > 0)      side_q.val <= 15'sd9000;
      else if (num_q < 0) side_q.val <= -15'sd9000;
      else                side_q.val <= '0;
    end
  end

  logic signed [ZvW-1:0] zv;
  sra_side_t             side_v;

  sra_vec #(.ITER(N)) u_vec (
    .clk_i  (clk_i),
    .en_i   (en[SV+N-1:SV]),
    .x_i    (vx_q),
    .y_i    (vy_q),
    .side_i (side_q),
    .z_o    (zv),
    .side_o (side_v)
  );

  // round to nearest hundredth, clamp
  logic signed [ZvW-1:0] zr;
  logic signed [17:0]    r;
  logic signed [14:0]    ang_q;

  assign zr = zv + ZvW'(32768);
  assign r  = zr[ZvW-1:16];

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      if (side_v.zero)          ang_q <= side_v.val;
      else if (r > 18'sd9000)   ang_q <= 15'sd9000;
      else if (r < -18'sd9000)  ang_q <= -15'sd9000;
      else                      ang_q <= r[14:0];
    end
  end

  assign out_valid_o   = v_q[NS-1];
  assign rotor_angle_o = ang_q;

  // the front stage only refuses an item when it holds one itself
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v_q[0])
    else $error("input stalled with empty front stage");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rotor_angle_o <= 15'sd9000) && (rotor_angle_o >= -15'sd9000))
    else $error("rotor angle out of range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !v_q[NS-2] |=> !out_valid_o)
    else $error("result repeated after delivery");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !en[1] |=> v_q[0])
    else $error("front item lost under stall");

endmodule

// ===== hw/rtl/sra_rot.sv =====
// ----------------------------------------------------------------------------
// sra_rot
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module sra_rot import sra_pkg::*; #(
  parameter int unsigned ITER = CordicIterDefault
) (
  input  logic                   clk_i,
  input  logic [ITER-1:0]        en_i,
  input  logic signed [ZrW-1:0]  z_i,
  input  logic                   flip_i,
  output logic signed [RotW-1:0] sin_o,
  output logic signed [RotW-1:0] cos_o
);

  logic signed [RotW-1:0] x_q [ITER];
  logic signed [RotW-1:0] y_q [ITER];
  logic signed [ZrW-1:0]  z_q [ITER];
  logic                   f_q [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    logic signed [RotW-1:0] xp, yp;
    logic signed [ZrW-1:0]  zp;
    logic                   fp;
    if (i == 0) begin : g_first
      assign xp = GainQ30;
      assign yp = '0;
      assign zp = z_i;
      assign fp = flip_i;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
      assign fp = f_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        f_q[i] <= fp;
        if (zp >= 0) begin
          x_q[i] <= xp - (yp >>> i);
          y_q[i] <= yp + (xp >>> i);
          z_q[i] <= zp - ATAN_TAB[i];
        end else begin
          x_q[i] <= xp + (yp >>> i);
          y_q[i] <= yp - (xp >>> i);
          z_q[i] <= zp + ATAN_TAB[i];
        end
      end
    end
  end

  assign sin_o = f_q[ITER-1] ? -y_q[ITER-1] : y_q[ITER-1];
  assign cos_o = f_q[ITER-1] ? -x_q[ITER-1] : x_q[ITER-1];

endmodule

// ===== hw/rtl/sra_vec.sv =====
// ----------------------------------------------------------------------------
// sra_vec
// Pipelined vectoring-mode CORDIC for the plain arctangent of y/x, x >= 0.
// ----------------------------------------------------------------------------
module sra_vec import sra_pkg::*; #(
  parameter int unsigned ITER = CordicIterDefault
) (
  input  logic                   clk_i,
  input  logic [ITER-1:0]        en_i,
  input  logic signed [VecW-1:0] x_i,
  input  logic signed [VecW-1:0] y_i,
  input  sra_side_t              side_i,
  output logic signed [ZvW-1:0]  z_o,
  output sra_side_t              side_o
);

  logic signed [VecW-1:0] x_q [ITER];
  logic signed [VecW-1:0] y_q [ITER];
  logic signed [ZvW-1:0]  z_q [ITER];
  sra_side_t              s_q [ITER];

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    logic signed [VecW-1:0] xp, yp;
    logic signed [ZvW-1:0]  zp, tab;
    sra_side_t              sp;
    if (i == 0) begin : g_first
      assign xp = x_i;
      assign yp = y_i;
      assign zp = '0;
      assign sp = side_i;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
      assign sp = s_q[i-1];
    end
    assign tab = ZvW'(ATAN_TAB[i]);
    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        s_q[i] <= sp;
        if (yp >= 0) begin
          x_q[i] <= xp + (yp >>> i);
          y_q[i] <= yp - (xp >>> i);
          z_q[i] <= zp + tab;
        end else begin
          x_q[i] <= xp - (yp >>> i);
          y_q[i] <= yp + (xp >>> i);
          z_q[i] <= zp - tab;
        end
      end
    end
  end

  assign z_o    = z_q[ITER-1];
  assign side_o = s_q[ITER-1];

endmodule

// ===== sim/satellite_rotor_angle_tb.sv =====
// ----------------------------------------------------------------------------
// satellite_rotor_angle_tb
// Drives satellite longitudes under random burst/stall timing, rewrites the
// site registers between phases and checks each rotor angle against an
// in-bench fixed-point CORDIC predictor.
// ----------------------------------------------------------------------------
module satellite_rotor_angle_tb;
  import sra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumIter = CordicIterDefault;
  localparam int unsigned Latency = 2 * NumIter + 4;
  localparam longint     CycleLimit = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] satellite_position_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [14:0] rotor_angle_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  satellite_rotor_angle dut (.*);

  always #2 clk_i = ~clk_i;

  logic signed [15:0] site_lon;
  logic signed [14:0] site_lat;
  logic signed [14:0] angle_q[$];
  int                 n_errors = 0;
  longint             cycle_cnt = 0;
  int                 burst_left = 0;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  task automatic sin_cos_q30(input longint a, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit     flip;
    flip = 0;
    a = ((a % 36000) + 36000) % 36000;
    if (a > 18000) a -= 36000;
    if (a > 9000) begin
      a -= 18000; flip = 1;
    end else if (a < -9000) begin
      a += 18000; flip = 1;
    end
    x = 652032874; y = 0; z = a * 65536;
    for (int i = 0; i < NumIter; i++) begin
      dx = floor_sh(y, i); dy = floor_sh(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  task automatic predict_angle(input logic signed [15:0] sat,
                               output logic signed [14:0] ang);
    longint sd, cd, sl, cl, x, y, z, dx, dy, r;
    sin_cos_q30(longint'(sat) - longint'(site_lon), sd, cd);
    sin_cos_q30(longint'(site_lat), sl, cl);
    y = 42164 * sd;
    x = 42164 * cd - 6348 * cl;
    if (x == 0) begin
      r = (y > 0) ? 9000 : ((y < 0) ? -9000 : 0);
    end else begin
      if (x < 0) begin
        x = -x; y = -y;
      end
      z = 0;
      for (int i = 0; i < NumIter; i++) begin
        dx = floor_sh(y, i); dy = floor_sh(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
        end else begin
          x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
        end
      end
      r = floor_sh(z + 32768, 16);
      if (r > 9000) r = 9000;
      if (r < -9000) r = -9000;
    end
    ang = r[14:0];
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall pattern: quiet stretches alternate with random stalling
  always @(negedge clk_i) begin
    if ((cycle_cnt / 500) % 3 == 0) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 99) < 35);
  end

  always @(posedge clk_i) begin
    logic signed [14:0] exp_ang;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (angle_q.size() == 0) begin
        $error("rotor_angle: unexpected item, actual %0d", rotor_angle_o);
        n_errors++;
      end else begin
        exp_ang = angle_q.pop_front();
        if (rotor_angle_o !== exp_ang) begin
          $error("rotor_angle: expected %0d actual %0d", exp_ang, rotor_angle_o);
          n_errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (angle_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic set_site(input logic signed [15:0] lon, input logic signed [14:0] lat);
    drain();
    write_reg(AddrSiteLon, 32'(lon));
    write_reg(AddrSiteLat, 32'(lat));
    site_lon = lon;
    site_lat = lat;
  endtask

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_position(input logic signed [15:0] pos, input bit gappy);
    logic signed [14:0] ang;
    int                 gap;
    if (gappy) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    satellite_position_i <= pos;
    predict_angle(pos, ang);
    do @(posedge clk_i); while (in_stall_o);
    angle_q.push_back(ang);
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    logic signed [15:0] pos_list[] = '{16'sd0, 16'sd18000, -16'sd18000, 16'sd9000,
      -16'sd9000, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sd27000, 16'sd17999,
      16'sh5555, -16'sh5556};
    foreach (pos_list[i]) send_position(pos_list[i], 0);
    idle_input();
  endtask

  task automatic test_site_extremes();
    logic signed [15:0] lons[] = '{16'sd18000, -16'sd18000, 16'sd32767, -16'sd32768};
    logic signed [14:0] lats[] = '{15'sd9000, -15'sd9000, 15'sd16383, -15'sd16384};
    foreach (lons[i]) begin
      set_site(lons[i], lats[i]);
      send_position(lons[i], 0);            // dlon zero
      send_position(lons[i] + 16'sd9000, 0);
      send_position(lons[i] - 16'sd9000, 0);
      send_position(16'sh7fff, 0);
      idle_input();
    end
  endtask

  task automatic test_random(input int count, input bit full_range);
    logic signed [15:0] pos;
    for (int i = 0; i < count; i++) begin
      if (full_range || $urandom_range(0, 9) == 0) pos = 16'($urandom);
      else pos = 16'(int'($urandom_range(0, 36000)) - 18000);
      send_position(pos, 1);
      if (i == count / 2) begin
        idle_input();
        while (angle_q.size() != 0) @(negedge clk_i);
      end
    end
    idle_input();
  endtask

  initial begin
    site_lon = '0;
    site_lat = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_site_extremes();
    set_site(16'sd1950, 15'sd4850);
    test_random(350, 0);
    set_site(16'(int'($urandom_range(0, 36000)) - 18000),
             15'(int'($urandom_range(0, 18000)) - 9000));
    test_random(350, 0);
    set_site(16'($urandom), 15'($urandom));
    test_random(350, 1);
    drain();
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/sra_pkg.sv
hw/rtl/sra_rot.sv
hw/rtl/sra_vec.sv
hw/rtl/satellite_rotor_angle.sv
sim/satellite_rotor_angle_tb.sv
